>>> design/isha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isha_pkg: shared types and constants for the iterated SHA-256 key stretcher
// Round constants, initial hash value, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package isha_pkg;

  localparam int SALT_BYTES_DEF = 16;
  localparam int ITER_W         = 21;
  localparam int SLEN_W         = 5;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SALT_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SALT_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_TOT  = 2'd3;

  localparam logic [ITER_W-1:0] ITER_RESET = 21'd1048576;
  localparam logic [SLEN_W-1:0] SLEN_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic start;   // load working vars from chaining value
    logic step;    // one round
    logic add;     // fold working vars into chaining value
  } core_ctl_t;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

>>> design/iterated_sha256_key_derivation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterated_sha256_key_derivation: iterated SHA-256 key stretching
// Channel  Dir  Beat contents (tdata, low bits first)
// in_      in   seed_word0..seed_word3, 256 bits
// out_     out  key_word0..key_word3, 256 bits
// cfg_     in   cfg_index selects salt_high, salt_low, salt_len, iteration_total
// Per iteration two compressions, each of one load, 64 rounds and one fold,
// all on the one round datapath. Input is not ready from acceptance until
// the key is taken.
// Reset is synchronous and restores the register defaults; output stalls hold.
// ----------------------------------------------------------------------------
module iterated_sha256_key_derivation
  import isha_pkg::*;
#(
  parameter int SALT_BYTES = SALT_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [255:0]         in_tdata,   // seed_word0, seed_word1, seed_word2, seed_word3
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [255:0]         out_tdata,  // key_word0, key_word1, key_word2, key_word3
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [63:0]        salt_high_r, salt_low_r;
  logic [SLEN_W-1:0]  salt_len_r;
  logic [ITER_W-1:0]  iter_tot_r;
  logic [255:0]       seed_r, run_r, run_nxt;
  logic [ITER_W-1:0]  ic_r, ic_nxt;
  logic [5:0]         rnd_r, rnd_nxt;
  logic               blk_r, blk_nxt;
  seq_state_t         state_r, state_nxt;
  core_ctl_t          ctl;
  logic [255:0]       chain_in, chain_out, fold_out;
  logic [511:0]       block;
  logic [127:0]       salt_area;
  logic [63:0]        ic_le;
  logic               out_valid_r, out_valid_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      salt_high_r <= '0;
      salt_low_r  <= '0;
      salt_len_r  <= SLEN_RESET;
      iter_tot_r  <= ITER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SALT_HIGH: salt_high_r <= cfg_data;
        REG_SALT_LOW:  salt_low_r  <= cfg_data;
        REG_SALT_LEN:  salt_len_r  <= cfg_data[SLEN_W-1:0];
        REG_ITER_TOT:  iter_tot_r  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // salt bytes at or past the effective length read as zero
  always_comb begin
    logic [127:0] s;
    s = {salt_high_r, salt_low_r};
    for (int i = 0; i < 16; i++) begin
      salt_area[127-8*i -: 8] = (i < SALT_BYTES && i < int'(salt_len_r)) ?
                                s[127-8*i -: 8] : 8'h00;
    end
  end

  always_comb begin
    logic [63:0] ic64;
    ic64 = {{(64-ITER_W){1'b0}}, ic_r};
    for (int i = 0; i < 8; i++) ic_le[63-8*i -: 8] = ic64[8*i +: 8];
  end

  assign block = blk_r ? {salt_area, ic_le, 8'h80, 248'd0, 64'd704}
                       : {run_r, seed_r[255:192], seed_r[191:128],
                          seed_r[127:64], seed_r[63:0]};
  assign chain_in = blk_r ? chain_out : H_INIT;

  isha_core u_core (
    .clk       (clk),
    .ctl       (ctl),
    .rnd       (rnd_r),
    .block     (block),
    .chain_in  (chain_in),
    .chain_out (chain_out),
    .fold_out  (fold_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ic_r  <= ic_nxt;
    rnd_r <= rnd_nxt;
    blk_r <= blk_nxt;
    run_r <= run_nxt;
    if (in_tvalid && in_tready) begin
      seed_r <= {in_tdata[63:0], in_tdata[127:64], in_tdata[191:128], in_tdata[255:192]};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    ic_nxt        = ic_r;
    rnd_nxt       = rnd_r;
    blk_nxt       = blk_r;
    run_nxt       = run_r;
    ctl           = '0;
    in_tready     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          run_nxt = '0;
          ic_nxt  = '0;
          blk_nxt = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (ic_r == iter_tot_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          ctl.start = 1'b1;
          rnd_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.step = 1'b1;
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        ctl.add   = 1'b1;
        state_nxt = ST_LOAD;
        if (blk_r) begin
          blk_nxt = 1'b0;
          ic_nxt  = ic_r + 1'b1;
          // folded digest of the second block is the new running hash
          run_nxt = fold_out;
        end else begin
          blk_nxt = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {run_r[63:0], run_r[127:64], run_r[191:128], run_r[255:192]};

endmodule

>>> design/isha_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isha_core: SHA-256 compression, one round per cycle while ctl.step is high
// Rolling 16-word schedule window and a single shared round datapath.
// ----------------------------------------------------------------------------
module isha_core
  import isha_pkg::*;
(
  input  logic         clk,
  input  core_ctl_t    ctl,
  input  logic [5:0]   rnd,
  input  logic [511:0] block,     // word 0 in the top bits
  input  logic [255:0] chain_in,  // h0 in the top bits
  output logic [255:0] chain_out,
  output logic [255:0] fold_out   // chaining value with the working vars folded in
);

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [255:0] chain_r;
  logic [255:0] fold;
  logic [31:0] wt, s0, s1, t1, t2, ws0, ws1, wnew;

  always_comb begin
    wt   = w_r[0];
    ws0  = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    ws1  = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
           ^ (w_r[14] >> 10);
    wnew = w_r[0] + ws0 + w_r[9] + ws1;
    s1 = {e_r[5:0], e_r[31:6]} ^ {e_r[10:0], e_r[31:11]} ^ {e_r[24:0], e_r[31:25]};
    s0 = {a_r[1:0], a_r[31:2]} ^ {a_r[12:0], a_r[31:13]} ^ {a_r[21:0], a_r[31:22]};
    t1 = h_r + s1 + ((e_r & f_r) ^ (~e_r & g_r)) + round_k(rnd) + wt;
    t2 = s0 + ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
    w_nxt[15] = wnew;
    fold = {chain_r[255:224] + a_r, chain_r[223:192] + b_r,
            chain_r[191:160] + c_r, chain_r[159:128] + d_r,
            chain_r[127:96]  + e_r, chain_r[95:64]   + f_r,
            chain_r[63:32]   + g_r, chain_r[31:0]    + h_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < 16; i++) w_r[i] <= block[511-32*i -: 32];
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= chain_in;
      chain_r <= chain_in;
    end else if (ctl.step) begin
      w_r <= w_nxt;
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end else if (ctl.add) begin
      chain_r <= fold;
    end
  end

  assign chain_out = chain_r;
  assign fold_out  = fold;

endmodule

>>> design/isha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isha_checker: port-level checks for the key stretcher
// Watches the stream ports only.
// ----------------------------------------------------------------------------
module isha_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [255:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while busy");

  a_busy_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while a key is pending");

endmodule

bind iterated_sha256_key_derivation isha_checker u_isha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> test/tb_iterated_sha256_key_derivation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iterated_sha256_key_derivation: self-checking bench for the key stretcher
// Directed table of seeds and register settings, then random seeds under
// random salts, salt lengths and small iteration counts. Every key is checked
// word by word against an in-bench SHA-256 predictor; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_iterated_sha256_key_derivation;
  import isha_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;

  localparam logic [31:0] KTAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [63:0]  salt_hi;
    logic [63:0]  salt_lo;
    logic [63:0]  slen_data;
    logic [63:0]  iter_data;
    logic [255:0] seed;      // {word3, word2, word1, word0}
    bit           known;
    logic [255:0] key;
  } vec_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [255:0]       in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [255:0]       out_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]        cfg_data;

  // bench copy of the registers
  logic [63:0]        salt_hi_q, salt_lo_q;
  logic [SLEN_W-1:0]  salt_len_q;
  logic [ITER_W-1:0]  iter_tot_q;

  logic [255:0]       key_queue [$];
  int                 errors;
  bit                 quiet;
  int                 ready_hold;
  longint             cycles;

  iterated_sha256_key_derivation dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [255:0] compress(input logic [255:0] hin, input logic [511:0] blk);
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hin[255 - 32 * i -: 32];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) compress[255 - 32 * i -: 32] = hin[255 - 32 * i -: 32] + v[i];
  endfunction

  // seed/key packed word0 lowest; message byte 0 sits in the top bits
  function automatic logic [255:0] stretch_key(input logic [255:0] seed);
    logic [1023:0] msg;
    logic [127:0]  salt;
    logic [255:0]  run, h;
    int            len;
    salt = {salt_hi_q, salt_lo_q};
    len = (salt_len_q > SALT_BYTES_DEF) ? SALT_BYTES_DEF : int'(salt_len_q);
    for (int i = len; i < 16; i++) salt[127 - 8 * i -: 8] = 8'h00;
    run = '0;
    for (int ic = 0; ic < int'(iter_tot_q); ic++) begin
      msg = '0;
      msg[1023 -: 256] = run;
      msg[767 -: 256]  = {seed[63:0], seed[127:64], seed[191:128], seed[255:192]};
      msg[511 -: 128]  = salt;
      for (int b = 0; b < 8; b++) msg[383 - 8 * b -: 8] = 8'(ic >> (8 * b));
      msg[319 -: 8]    = 8'h80;
      msg[63:0]        = 64'd704;
      h = compress(H_INIT, msg[1023:512]);
      run = compress(h, msg[511:0]);
    end
    return {run[63:0], run[127:64], run[191:128], run[255:192]};
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (key_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [63:0] sh, input logic [63:0] sl,
                            input logic [63:0] slen, input logic [63:0] iters);
    logic [63:0] vals [4];
    vals = '{sh, sl, slen, iters};
    for (int r = 0; r < 4; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      case (CFG_IDX_W'(r))
        REG_SALT_HIGH: salt_hi_q  <= vals[r];
        REG_SALT_LOW:  salt_lo_q  <= vals[r];
        REG_SALT_LEN:  salt_len_q <= vals[r][SLEN_W-1:0];
        REG_ITER_TOT:  iter_tot_q <= vals[r][ITER_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_seed(input logic [255:0] seed);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= seed;
    do @(posedge clk); while (!in_tready);
    key_queue.push_back(stretch_key(seed));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result side: random stall bursts, checks every key beat
  always @(posedge clk) begin
    logic [255:0] exp_key;
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (key_queue.size() == 0) begin
          $display("%0t: unexpected key beat, expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          exp_key = key_queue.pop_front();
          for (int k = 0; k < 4; k++)
            if (out_tdata[64 * k +: 64] !== exp_key[64 * k +: 64]) begin
              $display("%0t: key_word%0d expected %h actual %h", $time, k,
                       exp_key[64 * k +: 64], out_tdata[64 * k +: 64]);
              errors++;
            end
        end
      end
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        ready_hold <= $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("** iterated_sha256_key_derivation: FAILED **");
      $finish;
    end
  end

  initial begin
    vec_row_t    rows [12];
    logic [63:0] slen_d, iter_d;
    logic [255:0] seed;
    logic [255:0] got;
    rows = '{
      // zero iterations leave the running hash at zero
      '{64'h0, 64'h0, 64'd16, 64'd0, {256{1'b1}}, 1'b1, 256'h0},
      '{64'h0, 64'h0, 64'd16, 64'd0, 256'h0, 1'b1, 256'h0},
      '{64'h0, 64'h0, 64'd0, 64'd1, 256'h0, 1'b0, 256'h0},
      '{'1, '1, 64'd0, 64'd1, {256{1'b1}}, 1'b0, 256'h0},
      '{'1, '1, 64'd16, 64'd1, {256{1'b1}}, 1'b0, 256'h0},
      // salt length past the area acts as full length; upper data bits dropped
      '{'1, '1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 256'h0, 1'b0, 256'h0},
      '{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'd8, 64'd2,
        {64'h1, 64'h2, 64'h3, 64'h4}, 1'b0, 256'h0},
      '{64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 64'd1, 64'd2,
        {64'h1, 64'h2, 64'h3, 64'h4}, 1'b0, 256'h0},
      '{64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFE5,
        64'hFFFF_FFFF_FFE0_0003, {4{64'h8000_0000_0000_0001}}, 1'b0, 256'h0},
      '{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'd15, 64'd4,
        {4{64'h5a5a_5a5a_a5a5_a5a5}}, 1'b0, 256'h0},
      '{64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'd17, 64'd1,
        {4{64'hffff_0000_ffff_0000}}, 1'b0, 256'h0},
      '{'1, 64'h0, 64'd16, 64'd0, {4{64'hdead_beef_0bad_f00d}}, 1'b1, 256'h0}
    };
    errors = 0; quiet = 0; cycles = 0;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0;
    cfg_valid = 1'b0; cfg_index = REG_SALT_HIGH; cfg_data = '0;
    salt_hi_q = '0; salt_lo_q = '0; salt_len_q = SLEN_RESET; iter_tot_q = ITER_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset default iteration count is written but never run: far too slow
    write_regs(64'h0, 64'h0, 64'd16, 64'(ITER_RESET));

    foreach (rows[r]) begin
      drain();
      write_regs(rows[r].salt_hi, rows[r].salt_lo, rows[r].slen_data, rows[r].iter_data);
      send_seed(rows[r].seed);
      if (rows[r].known) begin
        got = key_queue[key_queue.size() - 1];
        if (got !== rows[r].key) begin
          $display("%0t: row %0d predictor expected %h actual %h", $time, r,
                   rows[r].key, got);
          errors++;
        end
      end
    end

    for (int n = 0; n < 90; n++) begin
      if (n % 10 == 0) begin
        drain();
        slen_d = (rand64() & 64'hFFFF_FFFF_FFFF_FFE0) | {59'd0, 5'($urandom_range(0, 31))};
        iter_d = (n == 40) ? 64'd24 : 64'($urandom_range(0, 4));
        iter_d = iter_d | (rand64() & 64'hFFFF_FFFF_FFE0_0000);
        write_regs(rand64(), rand64(), slen_d, iter_d);
      end
      if (n >= 80) quiet = 1;
      case ($urandom_range(0, 9))
        0:       seed = '0;
        1:       seed = '1;
        default: seed = {rand64(), rand64(), rand64(), rand64()};
      endcase
      send_seed(seed);
    end

    in_tvalid <= 1'b0;
    while (key_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** iterated_sha256_key_derivation: PASSED **");
    end else begin
      $display("** iterated_sha256_key_derivation: FAILED **");
    end
    $finish;
  end

endmodule
